### rtl/pdwc_pkg.sv
// Shared widths, constants and payload types of the PWM divider and wrap calculator.
package pdwc_pkg;

	localparam int FREQ_W   = 20;
	localparam int DUTY_W   = 16;
	localparam int CLK_W    = 28;
	localparam int DIV16_W  = 17;
	localparam int DEN_W    = DIV16_W + FREQ_W;
	localparam int NUM_W    = CLK_W + 4;
	localparam int WRAP_W   = 16;
	localparam int LEVEL_W  = 16;
	localparam int DINT_W   = 8;
	localparam int FRAC_W   = 4;
	localparam int D1_STEPS = CLK_W - 12;
	localparam int D2_STEPS = DIV16_W;
	localparam int PROD_W   = WRAP_W + DUTY_W;

	localparam logic [CLK_W-1:0]   CLK_RESET_HZ  = CLK_W'(125000000);
	localparam logic [DIV16_W-1:0] DIV16_MIN     = DIV16_W'(16);
	localparam logic [31:0]        DIV100_MAGIC  = 32'h51EB851F;
	localparam int                 DIV100_SHIFT  = 37;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [DUTY_W-1:0] duty;
		logic [CLK_W-1:0]  src_hz;
	} req_t;

	typedef struct packed {
		logic [FREQ_W-1:0]  freq;
		logic [DUTY_W-1:0]  duty;
		logic [CLK_W-1:0]   src_hz;
		logic [DIV16_W-1:0] div16;
	} div_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty;
		logic [DIV16_W-1:0] div16;
		logic [WRAP_W-1:0]  wrap;
	} wrap_t;

	typedef struct packed {
		logic              err;
		logic [LEVEL_W-1:0] level;
		logic [WRAP_W-1:0] wrap;
		logic [FRAC_W-1:0] frac;
		logic [DINT_W-1:0] dint;
	} res_t;

endpackage

### rtl/pdwc_div1.sv
// Pipelined divider that forms the clock divider in sixteenths, rounded up.
module pdwc_div1 import pdwc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	localparam int K = D1_STEPS + 2;

	typedef struct packed {
		logic [FREQ_W-1:0]   freq;
		logic [DUTY_W-1:0]   duty;
		logic [CLK_W-1:0]    src_hz;
		logic [D1_STEPS-1:0] acc;
		logic [FREQ_W-1:0]   rem;
		logic                low;
	} d1_t;

	// One restoring step: the dividend bit shifts into the remainder, the quotient bit in.
	function automatic d1_t d1_step(d1_t x);
		logic [FREQ_W:0] t;
		d1_t y;
		y = x;
		t = {x.rem, x.acc[D1_STEPS-1]};
		if (t >= {1'b0, x.freq}) begin
			t = t - {1'b0, x.freq};
			y.acc = {x.acc[D1_STEPS-2:0], 1'b1};
		end else begin
			y.acc = {x.acc[D1_STEPS-2:0], 1'b0};
		end
		y.rem = t[FREQ_W-1:0];
		return y;
	endfunction

	logic [K-1:0] v_q;
	logic [K-1:0] en;
	d1_t          pipe_s [K-1];
	div_t         fin_s;
	logic [DIV16_W-1:0] up;

	always_comb begin
		en[K-1] = !v_q[K-1] || out_ready;
		for (int i = K - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[K-1];
	assign out_data  = fin_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int i = 1; i < K; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	always_comb begin
		up = {1'b0, pipe_s[K-2].acc} +
			DIV16_W'((pipe_s[K-2].rem != '0) || pipe_s[K-2].low);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			// A zero frequency counts as 1 Hz. Divide the clock in units of 4096 by f.
			pipe_s[0].freq   <= (in_data.freq == '0) ? FREQ_W'(1) : in_data.freq;
			pipe_s[0].duty   <= in_data.duty;
			pipe_s[0].src_hz <= in_data.src_hz;
			pipe_s[0].acc    <= in_data.src_hz[CLK_W-1:12];
			pipe_s[0].rem    <= '0;
			pipe_s[0].low    <= (in_data.src_hz[11:0] != '0);
		end
		for (int i = 1; i < K - 1; i++) begin
			if (en[i]) begin
				pipe_s[i] <= d1_step(pipe_s[i-1]);
			end
		end
		if (en[K-1]) begin
			fin_s.freq   <= pipe_s[K-2].freq;
			fin_s.duty   <= pipe_s[K-2].duty;
			fin_s.src_hz <= pipe_s[K-2].src_hz;
			fin_s.div16  <= (up < DIV16_MIN) ? DIV16_MIN : up;
		end
	end

endmodule

### rtl/pdwc_div2.sv
// Pipelined divider that forms the counter wrap from the clock, divider and frequency.
module pdwc_div2 import pdwc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  div_t  in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output wrap_t out_data
);

	localparam int K = D2_STEPS + 3;

	typedef struct packed {
		logic [DUTY_W-1:0]   duty;
		logic [DIV16_W-1:0]  div16;
		logic [DEN_W-1:0]    den;
		logic [DEN_W-1:0]    rem;
		logic [D2_STEPS-1:0] acc;
		logic                ovf;
	} d2_t;

	function automatic d2_t d2_step(d2_t x);
		logic [DEN_W:0] t;
		d2_t y;
		y = x;
		t = {x.rem, x.acc[D2_STEPS-1]};
		if (t >= {1'b0, x.den}) begin
			t = t - {1'b0, x.den};
			y.acc = {x.acc[D2_STEPS-2:0], 1'b1};
		end else begin
			y.acc = {x.acc[D2_STEPS-2:0], 1'b0};
		end
		y.rem = t[DEN_W-1:0];
		return y;
	endfunction

	logic [K-1:0]        v_q;
	logic [K-1:0]        en;
	d2_t                 pipe_s [K-1];
	d2_t                 chk;
	wrap_t               fin_s;
	logic [NUM_W-1:0]    num;
	logic [D2_STEPS-1:0] quot;
	logic [D2_STEPS-1:0] qm1;
	logic [WRAP_W-1:0]   wrap;

	always_comb begin
		en[K-1] = !v_q[K-1] || out_ready;
		for (int i = K - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[K-1];
	assign out_data  = fin_s;
	assign num       = {in_data.src_hz, 4'b0000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int i = 1; i < K; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	// A quotient of 2^17 or more shows up as the upper dividend bits already reaching the
	// denominator; such an item saturates the wrap.
	always_comb begin
		chk     = pipe_s[0];
		chk.ovf = (pipe_s[0].rem >= pipe_s[0].den);
	end

	// The quotient is worked out to 17 bits; anything larger saturates the wrap anyway.
	always_comb begin
		quot = pipe_s[K-2].acc;
		qm1  = quot - D2_STEPS'(1);
		if (pipe_s[K-2].ovf || (qm1[D2_STEPS-1] && quot != '0)) begin
			wrap = '1;
		end else if (quot == '0) begin
			wrap = '0;
		end else begin
			wrap = qm1[WRAP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pipe_s[0].duty  <= in_data.duty;
			pipe_s[0].div16 <= in_data.div16;
			pipe_s[0].den   <= DEN_W'(in_data.div16) * DEN_W'(in_data.freq);
			pipe_s[0].rem   <= DEN_W'(num[NUM_W-1:D2_STEPS]);
			pipe_s[0].acc   <= num[D2_STEPS-1:0];
			pipe_s[0].ovf   <= 1'b0;
		end
		if (en[1]) begin
			pipe_s[1] <= chk;
		end
		for (int i = 2; i < K - 1; i++) begin
			if (en[i]) begin
				pipe_s[i] <= d2_step(pipe_s[i-1]);
			end
		end
		if (en[K-1]) begin
			fin_s.duty  <= pipe_s[K-2].duty;
			fin_s.div16 <= pipe_s[K-2].div16;
			fin_s.wrap  <= wrap;
		end
	end

endmodule

### rtl/pdwc_level.sv
// Compare level stages: wrap times duty, divided by 100, plus the divider fields.
module pdwc_level import pdwc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  wrap_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_data
);

	logic [2:0]          v_q;
	logic [2:0]          en;
	logic [PROD_W-1:0]   prod_s1;
	logic [DIV16_W-1:0]  div16_s1, div16_s2;
	logic [WRAP_W-1:0]   wrap_s1, wrap_s2;
	logic [63:0]         scaled_s2;
	res_t                res_s3;
	logic [DIV16_W-5:0]  dint_full;

	always_comb begin
		en[2] = !v_q[2] || out_ready;
		en[1] = !v_q[1] || en[2];
		en[0] = !v_q[0] || en[1];
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[2];
	assign out_data  = res_s3;
	assign dint_full = div16_s2[DIV16_W-1:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			if (en[1]) v_q[1] <= v_q[0];
			if (en[2]) v_q[2] <= v_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1  <= PROD_W'(in_data.wrap) * PROD_W'(in_data.duty);
			wrap_s1  <= in_data.wrap;
			div16_s1 <= in_data.div16;
		end
		// Division by 100 as a multiply by the rounded-up reciprocal and a shift.
		if (en[1]) begin
			scaled_s2 <= 64'(prod_s1) * 64'(DIV100_MAGIC);
			wrap_s2   <= wrap_s1;
			div16_s2  <= div16_s1;
		end
		if (en[2]) begin
			res_s3.wrap <= wrap_s2;
			res_s3.frac <= div16_s2[FRAC_W-1:0];
			if (scaled_s2[63:DIV100_SHIFT+LEVEL_W] != '0) begin
				res_s3.level <= '1;
			end else begin
				res_s3.level <= scaled_s2[DIV100_SHIFT+LEVEL_W-1:DIV100_SHIFT];
			end
			if (dint_full[DIV16_W-5:DINT_W] != '0) begin
				res_s3.dint <= '1;
				res_s3.err  <= 1'b1;
			end else begin
				res_s3.dint <= dint_full[DINT_W-1:0];
				res_s3.err  <= 1'b0;
			end
		end
	end

endmodule

### rtl/pwm_divider_wrap_calculator.sv
// Top level of the PWM clock divider, counter wrap and compare level calculator.
//
// For each requested PWM frequency and duty value this block returns the slice settings:
// the clock divider in sixteenths, ceil(source_clock_hz / (freq_hz * 4096)) and at least
// 1.0, split into an 8-bit integer and a 4-bit fraction; the counter wrap
// source_clock_hz * 16 / divider / freq_hz - 1 (never below 0, at most 65535); and the
// compare level wrap * duty_value / 100, saturated at 65535. A duty of 0xFFFF thus puts the
// level at or above the wrap, which holds the output on. A frequency of 0 is taken as 1 Hz.
// When the divider's integer part would exceed 255 it reads 255 and range_error is set; the
// fraction, wrap and level still come from the full divider. Every input transfer gives one
// output transfer, in order. The block takes one transfer per clock unless back-pressured,
// and holds 41 requests in flight: 18 stages for the first divider (load, one quotient bit
// per stage, then rounding), 20 for the second (product, range check, 17 quotient bits,
// wrap) and 3 for the level. Stages with no valid item fill up while the output is stalled,
// so the input keeps moving until the pipeline is full. source_clock_hz resets to 125 MHz
// and is rewritten with cfg_we; change it only while no request is in flight.
module pwm_divider_wrap_calculator import pdwc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CLK_W-1:0] cfg_wdata,   // source_clock_hz
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,     // freq_hz[19:0], duty_value[35:20], zeros
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [47:0]      m_tdata      // divider_integer[7:0], divider_fraction[11:8],
	                                      // counter_wrap[27:12], compare_level[43:28],
	                                      // range_error[44], zeros
);

	logic [CLK_W-1:0] src_hz_q;
	req_t             req;
	logic             d1_valid, d1_ready, d2_valid, d2_ready;
	div_t             d1_data;
	wrap_t            d2_data;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_hz_q <= CLK_RESET_HZ;
		end else if (cfg_we) begin
			src_hz_q <= cfg_wdata;
		end
	end

	assign req.freq   = s_tdata[FREQ_W-1:0];
	assign req.duty   = s_tdata[FREQ_W+DUTY_W-1:FREQ_W];
	assign req.src_hz = src_hz_q;

	pdwc_div1 u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (req),
		.out_valid (d1_valid),
		.out_ready (d1_ready),
		.out_data  (d1_data)
	);

	pdwc_div2 u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d1_valid),
		.in_ready  (d1_ready),
		.in_data   (d1_data),
		.out_valid (d2_valid),
		.out_ready (d2_ready),
		.out_data  (d2_data)
	);

	pdwc_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d2_valid),
		.in_ready  (d2_ready),
		.in_data   (d2_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	// The result struct is already laid out from the lowest field up.
	assign m_tdata = {3'b000, res};

endmodule

### tb/sv/pwm_divider_wrap_calculator_checker.sv
// Checker that predicts and compares the PWM divider, wrap and level results.
`timescale 1ns / 100ps
module pwm_divider_wrap_calculator_checker import pdwc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CLK_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [39:0]      s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [47:0]      m_tdata,
	output int               fail_count,
	output int               pending_count,
	output int               result_count
);

	typedef struct packed {
		logic              err;
		logic [15:0]       level;
		logic [15:0]       wrap;
		logic [3:0]        frac;
		logic [7:0]        dint;
	} slice_t;

	logic [CLK_W-1:0] src_hz;
	slice_t           slice_q[$];

	function automatic slice_t slice_settings(logic [CLK_W-1:0] hz, logic [19:0] freq_in,
		logic [15:0] duty);
		longint unsigned f, c, den, div16, quot, wrap, level, dint;
		slice_t r;
		f = freq_in;
		c = hz;
		if (f == 0) f = 1;
		den = f * 4096;
		div16 = c / den + ((c % den) != 0 ? 1 : 0);
		if (div16 / 16 == 0) div16 = 16;
		quot = c * 16 / div16 / f;
		wrap = (quot == 0) ? 0 : quot - 1;
		if (wrap > 65535) wrap = 65535;
		level = wrap * duty / 100;
		if (level > 65535) level = 65535;
		dint = div16 / 16;
		r.err = dint > 255;
		r.dint = (dint > 255) ? 8'd255 : dint[7:0];
		r.frac = div16[3:0];
		r.wrap = wrap[15:0];
		r.level = level[15:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slice_t got, want;
		if (!arst_n) begin
			src_hz <= CLK_RESET_HZ;
			fail_count <= 0;
			result_count <= 0;
			slice_q.delete();
		end else begin
			if (cfg_we) src_hz <= cfg_wdata;
			if (s_tvalid && s_tready)
				slice_q.push_back(slice_settings(src_hz, s_tdata[19:0], s_tdata[35:20]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[44:0];
				result_count <= result_count + 1;
				if (slice_q.size() == 0) begin
					$error("result with nothing expected: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = slice_q.pop_front();
					if (got.dint !== want.dint) $error("divider_integer exp %0d got %0d", want.dint, got.dint);
					if (got.frac !== want.frac) $error("divider_fraction exp %0d got %0d", want.frac, got.frac);
					if (got.wrap !== want.wrap) $error("counter_wrap exp %0d got %0d", want.wrap, got.wrap);
					if (got.level !== want.level) $error("compare_level exp %0d got %0d", want.level, got.level);
					if (got.err !== want.err) $error("range_error exp %0d got %0d", want.err, got.err);
					if (got !== want) fail_count <= fail_count + 1;
				end
			end
		end
	end

	assign pending_count = slice_q.size();

endmodule

### tb/sv/pwm_divider_wrap_calculator_tb.sv
// Top of the testbench for the PWM divider and wrap calculator: stimulus and verdict.
`timescale 1ns / 100ps
module pwm_divider_wrap_calculator_tb;
	import pdwc_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CLK_W-1:0] cfg_wdata;
	logic             s_tvalid, s_tready;
	logic [39:0]      s_tdata;
	logic             m_tvalid, m_tready;
	logic [47:0]      m_tdata;
	int               fail_count, pending_count, result_count;
	int               request_count;
	longint           cycle_count;

	localparam longint CYCLE_LIMIT = 200000;

	pwm_divider_wrap_calculator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	pwm_divider_wrap_calculator_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: the slowest correct run is far below this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// The result side may stall before each transfer; sometimes in long stretches it
	// never stalls at all.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ((request_count / 100) % 3 == 1) stall = 0;
			else stall = $urandom_range(0, 3);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Sends one request; the valid is held until the transfer happens.
	task automatic send_request(logic [19:0] freq, logic [15:0] duty, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, duty, freq};
		do @(posedge clk); while (!s_tready);
		request_count++;
		@(negedge clk);
	endtask

	// Waits until every request has its result, plus time for the pipeline to settle,
	// so that the clock register can be rewritten safely.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_clock(logic [CLK_W-1:0] hz);
		cfg_we <= 1'b1;
		cfg_wdata <= hz;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int n);
		logic [19:0] f;
		logic [15:0] d;
		bit burst;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: f = 20'($urandom);
				1: f = 20'($urandom_range(1, 1000));
				2: f = 20'($urandom_range(1, 1000000));
				default: f = 20'($urandom_range(1, 100000));
			endcase
			case ($urandom_range(0, 5))
				0: d = 16'($urandom);
				1: d = 16'hFFFF;
				default: d = 16'($urandom_range(0, 100));
			endcase
			burst = ((i / 40) % 3) == 2;
			send_request(f, d, burst);
		end
	endtask

	initial begin
		logic [CLK_W-1:0] clocks [6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cycle_count = 0;
		request_count = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed requests under the reset clock: extremes of both fields, zero frequency,
		// a saturated divider with the range error, a tiny wrap and the always-on duty.
		send_request(20'd0, 16'd50, 1'b0);
		send_request(20'd1, 16'd0, 1'b0);
		send_request(20'd1, 16'hFFFF, 1'b0);
		send_request(20'hFFFFF, 16'd100, 1'b0);
		send_request(20'd1000000, 16'hFFFF, 1'b0);
		send_request(20'd30, 16'd25, 1'b1);
		send_request(20'd122, 16'd99, 1'b1);
		send_request(20'd1907, 16'd100, 1'b0);
		send_request(20'd1908, 16'd101, 1'b0);
		send_request(20'd20000, 16'h8000, 1'b0);
		send_request(20'h55555, 16'h5555, 1'b0);
		send_request(20'hAAAAA, 16'hAAAA, 1'b0);
		random_phase(120);
		drain_pipeline();

		// Several clock settings including both extremes of the register field, zero, and
		// an all-ones value, each followed by random requests.
		clocks = '{28'd1000000, 28'd250000000, 28'hFFFFFFF, 28'd0, 28'd48000000,
			28'd125000000};
		foreach (clocks[k]) begin
			write_clock(clocks[k]);
			send_request(20'd0, 16'hFFFF, 1'b0);
			send_request(20'hFFFFF, 16'd100, 1'b0);
			random_phase(100);
			drain_pipeline();
		end

		$display("covered %0d requests and %0d results over %0d clock settings",
			request_count, result_count, 7);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### files.f
rtl/pdwc_pkg.sv
rtl/pdwc_div1.sv
rtl/pdwc_div2.sv
rtl/pdwc_level.sv
rtl/pwm_divider_wrap_calculator.sv
tb/sv/pwm_divider_wrap_calculator_checker.sv
tb/sv/pwm_divider_wrap_calculator_tb.sv
